// ===== src/i2c_master_bit_sequencer_defines.svh =====
// Assertion macros for the I2C master bit sequencer.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property that must hold in the same cycle.
`define I2CBS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("i2cbs check failed");
// Check a property that must hold in the next cycle.
`define I2CBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("i2cbs check failed");
`else
`define I2CBS_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define I2CBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== src/i2cbs_pkg.sv =====
// Shared types, codes and the fixed pin-write table of the I2C bit sequencer.
// No dependencies.
`timescale 1ns / 1ps

package i2cbs_pkg;

	// command codes
	typedef enum logic [2:0] {
		OP_START     = 3'd0,
		OP_STOP      = 3'd1,
		OP_ACK       = 3'd2,
		OP_NOACK     = 3'd3,
		OP_CHECK_ACK = 3'd4,
		OP_WRITE     = 3'd5,
		OP_READ      = 3'd6
	} op_t;

	localparam logic PIN_SCL = 1'b0;
	localparam logic PIN_SDA = 1'b1;

	localparam logic [7:0] MSB_MASK = 8'h80;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int IDX_W = 5;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] data_byte;
		logic [7:0] sampled_sda;
	} cmd_t;

	typedef struct packed {
		logic       pin;
		logic       level;
		logic       last;
		logic [7:0] read_value;
	} result_t;

	// classified command as it sits in the queue
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] last_idx;
		logic [7:0]       data_byte;
		logic [7:0]       sampled_sda;
	} entry_t;

	// index of the final pin write for a legal command
	function automatic logic [IDX_W-1:0] last_index(input op_t op);
		logic [IDX_W-1:0] n;
		case (op)
			OP_CHECK_ACK: n = 5'd1;
			OP_WRITE:     n = 5'd31;
			OP_READ:      n = 5'd15;
			default:      n = 5'd4;
		endcase
		return n;
	endfunction

	// {pin, level} of step idx for start, stop, ack and noack
	function automatic logic [1:0] fixed_step(input op_t op, input logic [2:0] idx);
		logic [1:0] pl;
		pl = {PIN_SCL, 1'b0};
		case (op)
			OP_START: begin
				case (idx)
					3'd1:    pl = {PIN_SDA, 1'b1};
					3'd2:    pl = {PIN_SCL, 1'b1};
					3'd3:    pl = {PIN_SDA, 1'b0};
					default: pl = {PIN_SCL, 1'b0};
				endcase
			end
			OP_STOP: begin
				case (idx)
					3'd1:    pl = {PIN_SDA, 1'b0};
					3'd2:    pl = {PIN_SCL, 1'b1};
					3'd3:    pl = {PIN_SDA, 1'b1};
					default: pl = {PIN_SCL, 1'b0};
				endcase
			end
			OP_ACK, OP_NOACK: begin
				case (idx)
					3'd1:    pl = {PIN_SDA, (op == OP_NOACK)};
					3'd2:    pl = {PIN_SCL, 1'b1};
					3'd4:    pl = {PIN_SDA, 1'b0};
					default: pl = {PIN_SCL, 1'b0};
				endcase
			end
			default: pl = {PIN_SCL, 1'b0};
		endcase
		return pl;
	endfunction

endpackage

// ===== src/i2cbs_front.sv =====
// Front end of the I2C bit sequencer: accepts commands, drops undefined codes,
// tags each with the index of its final step. Depends on i2cbs_pkg.
`timescale 1ns / 1ps

module i2cbs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  i2cbs_pkg::cmd_t   cmd,
	input  logic              full,
	output logic              push,
	output i2cbs_pkg::entry_t entry
);

	logic              valid_s1;
	i2cbs_pkg::entry_t entry_s1;
	logic              accept;
	logic              legal;

	// stall only while the held beat cannot move into the queue
	assign push   = valid_s1 & ~full;
	assign busy   = valid_s1 & full;
	assign accept = start & ~busy;
	assign entry  = entry_s1;

	// classify: every code but the unused one is a command
	always_comb begin
		case (cmd.op)
			i2cbs_pkg::OP_START, i2cbs_pkg::OP_STOP, i2cbs_pkg::OP_ACK,
			i2cbs_pkg::OP_NOACK, i2cbs_pkg::OP_CHECK_ACK, i2cbs_pkg::OP_WRITE,
			i2cbs_pkg::OP_READ: legal = 1'b1;
			default:            legal = 1'b0;
		endcase
	end

	// hold the stage until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= legal;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// load payload on each accepted legal beat
	always_ff @(posedge clk) begin
		if (accept && legal) begin
			entry_s1.op          <= i2cbs_pkg::op_t'(cmd.op);
			entry_s1.last_idx    <= i2cbs_pkg::last_index(i2cbs_pkg::op_t'(cmd.op));
			entry_s1.data_byte   <= cmd.data_byte;
			entry_s1.sampled_sda <= cmd.sampled_sda;
		end
	end

endmodule

// ===== src/i2cbs_queue.sv =====
// Small command queue between front end and sequencer, in flip-flops.
// Depends on i2cbs_pkg.
`timescale 1ns / 1ps

module i2cbs_queue #(
	parameter int DEPTH = i2cbs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  i2cbs_pkg::entry_t        wr_entry,
	output logic                     full,
	input  logic                     pop,
	output logic                     not_empty,
	output i2cbs_pkg::entry_t        rd_entry,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	i2cbs_pkg::entry_t      slot_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   do_push;
	logic                   do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push & ~full;
	assign do_pop    = pop & not_empty;
	assign rd_entry  = slot_q[rd_ptr_q];
	assign count     = count_q;

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// write the incoming beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

// ===== src/i2cbs_back.sv =====
// Sequencer back end: steps through one command's pin writes, one per cycle.
// Depends on i2cbs_pkg.
`timescale 1ns / 1ps

module i2cbs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               not_empty,
	input  i2cbs_pkg::entry_t  head,
	output logic               pop,
	output logic               strobe,
	output i2cbs_pkg::result_t result
);

	localparam int IDX_W = i2cbs_pkg::IDX_W;

	logic               active_q;
	i2cbs_pkg::op_t     op_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   last_idx_q;
	logic [7:0]         data_q;
	logic [7:0]         samp_q;
	logic               strobe_q;
	i2cbs_pkg::result_t result_q;
	i2cbs_pkg::result_t cur;
	logic               at_last;
	logic [1:0]         fixed_pl;

	assign at_last  = active_q & (idx_q == last_idx_q);
	assign pop      = not_empty & (~active_q | at_last);
	assign strobe   = strobe_q;
	assign result   = result_q;
	assign fixed_pl = i2cbs_pkg::fixed_step(op_q, idx_q[2:0]);

	// form the pin write of the current step
	always_comb begin
		cur.pin        = i2cbs_pkg::PIN_SCL;
		cur.level      = 1'b0;
		cur.last       = at_last;
		cur.read_value = 8'h00;
		case (op_q)
			i2cbs_pkg::OP_START, i2cbs_pkg::OP_STOP, i2cbs_pkg::OP_ACK,
			i2cbs_pkg::OP_NOACK: begin
				cur.pin   = fixed_pl[1];
				cur.level = fixed_pl[0];
			end
			i2cbs_pkg::OP_CHECK_ACK: begin
				cur.level = ~idx_q[0];
				if (at_last) begin
					cur.read_value = {7'b0, ((samp_q & i2cbs_pkg::MSB_MASK) != 8'h00)};
				end
			end
			i2cbs_pkg::OP_WRITE: begin
				case (idx_q[1:0])
					2'd0: begin
						cur.pin   = i2cbs_pkg::PIN_SDA;
						cur.level = data_q[7];
					end
					2'd1:    cur.level = 1'b1;
					2'd2:    cur.level = 1'b0;
					default: cur.pin   = i2cbs_pkg::PIN_SDA;
				endcase
			end
			i2cbs_pkg::OP_READ: begin
				cur.level = ~idx_q[0];
				if (at_last) begin
					cur.read_value = samp_q;
				end
			end
			default: cur.level = 1'b0;
		endcase
	end

	// control: load a command from the queue, advance the step, drop when done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (at_last) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// payload: command fields and the registered result beat
	always_ff @(posedge clk) begin
		result_q <= cur;
		if (pop) begin
			op_q       <= head.op;
			last_idx_q <= head.last_idx;
			data_q     <= head.data_byte;
			samp_q     <= head.sampled_sda;
		end else if (active_q && op_q == i2cbs_pkg::OP_WRITE && idx_q[1:0] == 2'd3) begin
			data_q <= {data_q[6:0], 1'b0};
		end
	end

endmodule

// ===== src/i2c_master_bit_sequencer.sv =====
// I2C master bit sequencer: one command in, its pin writes out, one per cycle.
// The first pin write passes the front stage, a queue slot, the step registers
// and the result register before it is strobed.
// A command has 2 pin writes for check ack, 5 for start/stop/ack/noack, 16 for
// read and 32 for write; a queued command follows the last write without a gap.
// Reset clears the front stage, queue and sequencer; results cannot be stalled.
`timescale 1ns / 1ps
`include "i2c_master_bit_sequencer_defines.svh"

module i2c_master_bit_sequencer #(
	parameter int QUEUE_DEPTH = i2cbs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  i2cbs_pkg::cmd_t    cmd,
	output logic               strobe,
	output i2cbs_pkg::result_t result
);

	logic                            push;
	logic                            full;
	logic                            pop;
	logic                            not_empty;
	i2cbs_pkg::entry_t               wr_entry;
	i2cbs_pkg::entry_t               rd_entry;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

	// accept and classify commands
	i2cbs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.full   (full),
		.push   (push),
		.entry  (wr_entry)
	);

	// decouple front end from sequencer
	i2cbs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.rd_entry  (rd_entry),
		.count     (q_count)
	);

	// step out pin writes
	i2cbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (rd_entry),
		.pop       (pop),
		.strobe    (strobe),
		.result    (result)
	);

	// a command's writes come without gaps
	`I2CBS_ASSERT_NEXT(a_no_gap, clk, arst_n, strobe && !result.last, strobe)
	// read data appears only on a final write
	`I2CBS_ASSERT_NOW(a_value_last, clk, arst_n, strobe && result.read_value != 8'h00, result.last)
	// occupancy stays within the queue
	`I2CBS_ASSERT_NOW(a_q_bound, clk, arst_n, 1'b1, q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
	// stall only while the queue is full
	`I2CBS_ASSERT_NOW(a_busy_full, clk, arst_n, busy, full)

endmodule
